FILE: rtl/tbd_pkg.sv
// Shared types, constants and the character-to-slot map of the DNA trie builder.
`timescale 1ns / 1ps

package tbd_pkg;

   localparam int SLOTS         = 5;
   localparam int MAX_NODES_DEF = 1024;
   localparam int NODE_OUT_W    = 10;
   localparam int SLOT_W        = 3;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_END = 8'h24;

   localparam logic [SLOT_W-1:0] SLOT_A   = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_C   = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_G   = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_T   = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_END = 3'd4;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       pattern_end;
   } req_item_type;

   typedef struct packed {
      logic [NODE_OUT_W-1:0] node_index;
      logic                  created;
      logic                  full_res;
   } rsp_item_type;

   typedef struct packed {
      logic accept;
      logic resolve;
      logic clear_step;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
   } dp_sts_type;

   function automatic slot_type char_to_slot(input logic [7:0] c);
      slot_type s;
      unique case (c)
         CHAR_C:   s = SLOT_C;
         CHAR_G:   s = SLOT_G;
         CHAR_T:   s = SLOT_T;
         CHAR_END: s = SLOT_END;
         default:  s = SLOT_A;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/tbd_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module tbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tbd_ctrl.sv
// Controller: clearing sweep, item acceptance, resolve step and result valid.
`timescale 1ns / 1ps

module tbd_ctrl import tbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RESOLVE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   always_comb begin
      rsp_free       = !rsp_valid_ff || !rsp_stall;
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.accept     = (state_ff == ST_IDLE) && req_valid;
      cmd.resolve    = (state_ff == ST_RESOLVE) && rsp_free;

      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase

      if (cmd.resolve) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/tbd_dpath.sv
// Datapath: walk registers, allocation counter, child-row store and result register.
`timescale 1ns / 1ps

module tbd_dpath import tbd_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  dp_cmd_type   cmd,
   output dp_sts_type   sts,
   input  req_item_type req_payload,
   output rsp_item_type rsp_payload
);

   localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int ROW_W = NW * SLOTS;
   localparam int EW    = (NW > NODE_OUT_W) ? NW : NODE_OUT_W;
   localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

   logic [NW-1:0]    cur_ff, cur_in;
   logic [NW-1:0]    next_free_ff, next_free_in;
   logic [NW-1:0]    clr_cnt_ff, clr_cnt_in;
   slot_type         slot_ff;
   logic             end_ff;
   rsp_item_type     rsp_payload_ff, rsp_payload_in;

   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] upd_row;
   logic [ROW_W-1:0] wr_row;
   logic [NW-1:0]    child;
   logic [NW-1:0]    new_idx;
   logic [NW-1:0]    reach;
   logic [NW-1:0]    mem_addr;
   logic [EW-1:0]    reach_ext;
   logic             hit;
   logic             can_alloc;
   logic             alloc;
   logic             mem_we;

   always_comb begin
      child   = '0;
      upd_row = rd_row;
      new_idx = next_free_ff + NW'(1);
      for (int s = 0; s < SLOTS; s++) begin
         if (slot_ff == SLOT_W'(s)) begin
            child                 = rd_row[s*NW +: NW];
            upd_row[s*NW +: NW]   = new_idx;
         end
      end

      hit       = (child != '0);
      can_alloc = (next_free_ff != LAST_NODE);
      alloc     = cmd.resolve && !hit && can_alloc;

      if (hit) begin
         reach = child;
      end else if (can_alloc) begin
         reach = new_idx;
      end else begin
         reach = cur_ff;
      end
      reach_ext = EW'(reach);

      rsp_payload_in            = rsp_payload_ff;
      cur_in                    = cur_ff;
      next_free_in              = next_free_ff;
      if (cmd.resolve) begin
         rsp_payload_in.node_index = reach_ext[NODE_OUT_W-1:0];
         rsp_payload_in.created    = !hit && can_alloc;
         rsp_payload_in.full_res   = !hit && !can_alloc;
         cur_in                    = end_ff ? '0 : reach;
      end
      if (alloc) begin
         next_free_in = new_idx;
      end

      clr_cnt_in = cmd.clear_step ? clr_cnt_ff + NW'(1) : clr_cnt_ff;

      mem_we   = cmd.clear_step || alloc;
      mem_addr = cmd.clear_step ? clr_cnt_ff : cur_ff;
      wr_row   = cmd.clear_step ? '0 : upd_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         next_free_ff <= '0;
         clr_cnt_ff   <= '0;
      end else begin
         cur_ff       <= cur_in;
         next_free_ff <= next_free_in;
         clr_cnt_ff   <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         slot_ff <= char_to_slot(req_payload.char_code);
         end_ff  <= req_payload.pattern_end;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   tbd_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_NODES)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (cmd.accept),
      .addr    (mem_addr),
      .wr_data (wr_row),
      .rd_data (rd_row)
   );

   assign sts.clear_done = (clr_cnt_ff == LAST_NODE);
   assign rsp_payload    = rsp_payload_ff;

endmodule

FILE: rtl/trie_builder_dna_unit.sv
// Top level of the DNA trie builder: controller plus datapath.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_item_type: char_code, pattern_end
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_item_type: node_index, created, full_res
//
// After reset the child store is swept to zero, one node row per cycle, with req_stall
// high. Each item passes through two steps: the registered read of the current node's
// child row on acceptance, then the resolve step, which picks the slot, writes back the
// row on allocation and loads the result register.
// One item is in flight at a time; a stalled result holds the next item in the resolve step.
`timescale 1ns / 1ps

module trie_builder_dna_unit import tbd_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_payload
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   tbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tbd_dpath #(
      .MAX_NODES (MAX_NODES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/tbd_checker.sv
// Port-level assertions for the DNA trie builder, bound to the top level.
`timescale 1ns / 1ps

module tbd_checker import tbd_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_payload,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken before the first resolved");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.created && rsp_payload.full_res))
      else $error("created and full both set");

endmodule

bind trie_builder_dna_unit tbd_checker u_tbd_checker (.*);
